// ===== sv/beep_and_led_tick_pattern_macros.svh =====
// Assertion helpers used by the pattern sequencer core.
`ifndef BEEP_AND_LED_TICK_PATTERN_MACROS_SVH
`define BEEP_AND_LED_TICK_PATTERN_MACROS_SVH

// Checked on every edge outside reset.
`define BLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define BLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/blp_pkg.sv =====
// ----------------------------------------------------------------------------
// blp_pkg
// Types and constants of the beep and LED tick pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package blp_pkg;

  localparam int unsigned NumLeds   = 3;
  localparam int unsigned TickWidth = 16;
  localparam int unsigned RingWidth = 8;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // Register resets in ticks (100 ms, 50 ms, 200 ms, 100 ms at 10 ms a tick).
  localparam logic [TickWidth-1:0] BeepPeriodReset = 16'd10;
  localparam logic [TickWidth-1:0] BeepOnReset     = 16'd5;
  localparam logic [TickWidth-1:0] LedPeriodReset  = 16'd20;
  localparam logic [TickWidth-1:0] LedOnReset      = 16'd10;

  typedef enum logic [1:0] {
    REG_BEEP_PERIOD = 2'd0,
    REG_BEEP_ON     = 2'd1,
    REG_LED_PERIOD  = 2'd2,
    REG_LED_ON      = 2'd3
  } blp_reg_e;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } blp_cmd_e;

  typedef struct packed {
    logic [TickWidth-1:0] led_on_ticks;
    logic [TickWidth-1:0] led_period_ticks;
    logic [TickWidth-1:0] beep_on_ticks;
    logic [TickWidth-1:0] beep_period_ticks;
  } blp_cfg_t;

  typedef struct packed {
    blp_cmd_e             cmd;
    logic [NumLeds-1:0]   led_blink;
    logic [NumLeds-1:0]   led_enable;
    logic [RingWidth-1:0] ring_count;
  } blp_item_t;

  typedef struct packed {
    logic [NumLeds-1:0] led_levels;
    logic               beep_level;
  } blp_result_t;

endpackage

`default_nettype wire

// ===== sv/blp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// blp_cfg_regs
// APB register file holding the beep and LED timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_cfg_regs import blp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready,
  output blp_cfg_t                  cfg_o
);

  blp_cfg_t cfg_q, cfg_d;
  blp_reg_e addr_reg;
  logic     wr_en;

  assign pready   = 1'b1;
  assign addr_reg = blp_reg_e'(paddr[AddrWidth-1:2]);
  assign wr_en    = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (addr_reg)
        REG_BEEP_PERIOD: cfg_d.beep_period_ticks = pwdata[TickWidth-1:0];
        REG_BEEP_ON:     cfg_d.beep_on_ticks     = pwdata[TickWidth-1:0];
        REG_LED_PERIOD:  cfg_d.led_period_ticks  = pwdata[TickWidth-1:0];
        REG_LED_ON:      cfg_d.led_on_ticks      = pwdata[TickWidth-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beep_period_ticks <= BeepPeriodReset;
      cfg_q.beep_on_ticks     <= BeepOnReset;
      cfg_q.led_period_ticks  <= LedPeriodReset;
      cfg_q.led_on_ticks      <= LedOnReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (addr_reg)
      REG_BEEP_PERIOD: prdata = {{(DataWidth-TickWidth){1'b0}}, cfg_q.beep_period_ticks};
      REG_BEEP_ON:     prdata = {{(DataWidth-TickWidth){1'b0}}, cfg_q.beep_on_ticks};
      REG_LED_PERIOD:  prdata = {{(DataWidth-TickWidth){1'b0}}, cfg_q.led_period_ticks};
      REG_LED_ON:      prdata = {{(DataWidth-TickWidth){1'b0}}, cfg_q.led_on_ticks};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/blp_core.sv =====
// ----------------------------------------------------------------------------
// blp_core
// Tick state (parity, phases, ring sequencer) and per-tick beep/LED levels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "beep_and_led_tick_pattern_macros.svh"

module blp_core import blp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  blp_item_t  item_i,
  input  blp_cfg_t   cfg_i,
  output blp_result_t result_o
);

  logic                 parity_q, parity_d;
  logic [TickWidth-1:0] beep_phase_q, beep_phase_d;
  logic [TickWidth-1:0] led_phase_q, led_phase_d;
  logic                 active_q, active_d;
  logic [TickWidth-1:0] elapsed_q, elapsed_d;
  logic [RingWidth-1:0] rings_q, rings_d;

  logic [TickWidth:0]   beep_phase_inc, led_phase_inc, elapsed_inc;
  logic                 in_window;
  logic                 is_tick;

  assign is_tick = step_i && (item_i.cmd == CMD_TICK);

  always_comb begin
    parity_d     = parity_q;
    beep_phase_d = beep_phase_q;
    led_phase_d  = led_phase_q;
    active_d     = active_q;
    elapsed_d    = elapsed_q;
    rings_d      = rings_q;
    result_o     = '0;

    // A period of zero behaves as one: phase + 1 is always >= 1.
    beep_phase_inc = {1'b0, beep_phase_q} + 17'd1;
    led_phase_inc  = {1'b0, led_phase_q} + 17'd1;
    elapsed_inc    = {1'b0, elapsed_q} + 17'd1;
    in_window      = 1'b0;

    if (step_i && item_i.cmd == CMD_LOAD) begin
      rings_d = item_i.ring_count;
    end else if (is_tick) begin
      parity_d     = ~parity_q;
      beep_phase_d = (beep_phase_inc >= {1'b0, cfg_i.beep_period_ticks})
                     ? '0 : beep_phase_inc[TickWidth-1:0];
      led_phase_d  = (led_phase_inc >= {1'b0, cfg_i.led_period_ticks})
                     ? '0 : led_phase_inc[TickWidth-1:0];

      if (active_q) begin
        result_o.beep_level = (elapsed_q < cfg_i.beep_on_ticks);
        if (elapsed_inc >= {1'b0, cfg_i.beep_period_ticks}) begin
          active_d  = 1'b0;
          elapsed_d = '0;
        end else begin
          elapsed_d = elapsed_inc[TickWidth-1:0];
        end
      end else begin
        elapsed_d = '0;
      end

      // Start the next queued ring on a beep period boundary.
      if (beep_phase_d == '0 && rings_q != '0) begin
        rings_d   = rings_q - 8'd1;
        elapsed_d = '0;
        active_d  = 1'b1;
      end

      // LEDs light only on even ticks.
      if (!parity_d) begin
        in_window           = (led_phase_d < cfg_i.led_on_ticks);
        result_o.led_levels = item_i.led_enable & (~item_i.led_blink | {NumLeds{in_window}});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q     <= 1'b0;
      beep_phase_q <= '0;
      led_phase_q  <= '0;
      active_q     <= 1'b0;
      elapsed_q    <= '0;
      rings_q      <= '0;
    end else begin
      parity_q     <= parity_d;
      beep_phase_q <= beep_phase_d;
      led_phase_q  <= led_phase_d;
      active_q     <= active_d;
      elapsed_q    <= elapsed_d;
      rings_q      <= rings_d;
    end
  end

  `BLP_ASSERT_ALWAYS(a_idle_elapsed_zero, !active_q |-> elapsed_q == '0, "elapsed count nonzero while no ring runs")
  `BLP_ASSERT(a_beep_needs_ring, result_o.beep_level |-> active_q, "beep driven without a ring in progress")
  `BLP_ASSERT(a_ring_dequeue_by_one, is_tick |=> (rings_q == $past(rings_q) || rings_q == $past(rings_q) - 8'd1), "ring queue moved by more than one on a tick")
  `BLP_ASSERT(a_parity_on_tick, is_tick |=> parity_q != $past(parity_q), "parity did not toggle on a tick")

endmodule

`default_nettype wire

// ===== sv/beep_and_led_tick_pattern.sv =====
// One tick word or load word is accepted per clock cycle while the pipeline does not
// stall. Each word is held in an input register; when it advances, the tick state
// updates and the levels are computed into the result register, from which a tick
// result is offered; load words update the ring queue and give no result. The
// result register stalls when the result side is not ready, and the input register
// stalls with it while it holds a word.
// ----------------------------------------------------------------------------
// beep_and_led_tick_pattern
// Tick-driven buzzer ring sequencer and three-LED steady/blink driver.
// ----------------------------------------------------------------------------
`default_nettype none

module beep_and_led_tick_pattern import blp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // stream in
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [15:0]          s_axis_tdata,  // [7:0] ring_count, [10:8] led_enable,
                                                   // [13:11] led_blink, [15:14] zero
  input  wire logic                 s_axis_tuser,  // [0] cmd
  // stream out
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [0] beep_level, [3:1] led_levels,
                                                   // [7:4] zero
  // config
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready
);

  blp_cfg_t    cfg;
  blp_item_t   in_item_q;
  logic        in_valid_q;
  blp_result_t result;
  blp_result_t out_result_q;
  logic        out_valid_q;
  logic        advance;
  logic        fire;

  blp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cmd        <= blp_cmd_e'(s_axis_tuser);
      in_item_q.ring_count <= s_axis_tdata[7:0];
      in_item_q.led_enable <= s_axis_tdata[10:8];
      in_item_q.led_blink  <= s_axis_tdata[13:11];
    end
  end

  blp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Drop the slot for load words: they give no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && (in_item_q.cmd == CMD_TICK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_result_q.led_levels, out_result_q.beep_level};

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the beep and LED tick pattern sequencer. Tick and
// load words stream in with random gaps and receiver stalls; a scoreboard
// tracks the ring queue, the phase counters and the LED windows and checks
// each result word in order. The timing registers are rewritten between
// phases over the APB port, extremes included, and read back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import blp_pkg::*;

  class pattern_scoreboard;
    logic [15:0]  beep_period, beep_on, led_period, led_on;
    bit           parity;
    bit           ring_active;
    logic [15:0]  beep_phase, led_phase, ring_elapsed;
    logic [7:0]   rings_left;
    blp_result_t  levels_q[$];
    int           errors;

    function new();
      beep_period  = BeepPeriodReset;
      beep_on      = BeepOnReset;
      led_period   = LedPeriodReset;
      led_on       = LedOnReset;
      parity       = 1'b0;
      ring_active  = 1'b0;
      beep_phase   = '0;
      led_phase    = '0;
      ring_elapsed = '0;
      rings_left   = '0;
      errors       = 0;
    endfunction

    function int unsigned span(logic [15:0] period);
      return (period == 16'd0) ? 1 : int'(period);
    endfunction

    function logic [15:0] next_phase(logic [15:0] phase, logic [15:0] period);
      int unsigned nxt;
      nxt = int'(phase) + 1;
      if (nxt >= span(period)) nxt = 0;
      return nxt[15:0];
    endfunction

    function void set_reg(blp_reg_e idx, logic [15:0] value);
      case (idx)
        REG_BEEP_PERIOD: beep_period = value;
        REG_BEEP_ON:     beep_on     = value;
        REG_LED_PERIOD:  led_period  = value;
        REG_LED_ON:      led_on      = value;
        default: ;
      endcase
    endfunction

    function void note_word(blp_item_t w);
      blp_result_t  lv;
      int unsigned  nxt;
      bit           in_window;
      if (w.cmd == CMD_LOAD) begin
        rings_left = w.ring_count;
        return;
      end
      parity     = ~parity;
      beep_phase = next_phase(beep_phase, beep_period);
      led_phase  = next_phase(led_phase, led_period);
      lv = '0;
      if (ring_active) begin
        lv.beep_level = (ring_elapsed < beep_on);
        nxt = int'(ring_elapsed) + 1;
        if (nxt >= span(beep_period)) begin
          ring_active  = 1'b0;
          ring_elapsed = '0;
        end else begin
          ring_elapsed = nxt[15:0];
        end
      end else begin
        ring_elapsed = '0;
      end
      // start the next queued ring on a beep period boundary
      if (beep_phase == 16'd0 && rings_left != 8'd0) begin
        rings_left   = rings_left - 8'd1;
        ring_elapsed = '0;
        ring_active  = 1'b1;
      end
      in_window = (led_phase < led_on);
      if (!parity) begin
        for (int i = 0; i < NumLeds; i++) begin
          if (w.led_enable[i] && (!w.led_blink[i] || in_window)) lv.led_levels[i] = 1'b1;
        end
      end
      levels_q.push_back(lv);
    endfunction

    function void check_word(blp_result_t got);
      blp_result_t want;
      if (levels_q.size() == 0) begin
        $display("%0t: unexpected result word beep %0b leds %03b", $time,
                 got.beep_level, got.led_levels);
        errors++;
        return;
      end
      want = levels_q.pop_front();
      if (got.beep_level !== want.beep_level) begin
        $display("%0t: beep_level expected %0b actual %0b", $time,
                 want.beep_level, got.beep_level);
        errors++;
      end
      if (got.led_levels !== want.led_levels) begin
        $display("%0t: led_levels expected %03b actual %03b", $time,
                 want.led_levels, got.led_levels);
        errors++;
      end
    endfunction

    function int pending();
      return levels_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;  // [7:0] ring_count, [10:8] led_enable,
                                            // [13:11] led_blink, [15:14] zero
  logic                 s_axis_tuser = 1'b0;  // [0] cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;  // [0] beep_level, [3:1] led_levels, [7:4] zero
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  pattern_scoreboard sb = new();

  bit tx_calm  = 1'b0;
  bit rx_calm  = 1'b0;
  bit hold_req = 1'b0;

  beep_and_led_tick_pattern u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check accepted words, stall at random or on request
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata[3:0]);
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = 300;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (rx_calm) begin
        m_axis_tready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_axis_tready = 1'b1;
        end else begin
          m_axis_tready = 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("beep_and_led_tick_pattern verification failed");
    $finish;
  end

  function automatic blp_item_t make_word();
    blp_item_t w;
    w.ring_count = 8'($urandom_range(0, 255));
    w.led_enable = 3'($urandom_range(0, 7));
    w.led_blink  = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 15) begin
      w.cmd = CMD_LOAD;
      if ($urandom_range(0, 9) < 7) w.ring_count = 8'($urandom_range(0, 3));
    end else begin
      w.cmd = CMD_TICK;
    end
    return w;
  endfunction

  function automatic blp_item_t word_of(blp_cmd_e cmd, logic [7:0] count,
                                        logic [2:0] en, logic [2:0] bl);
    blp_item_t w;
    w.cmd        = cmd;
    w.ring_count = count;
    w.led_enable = en;
    w.led_blink  = bl;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input blp_item_t w);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, w[13:0]};
    s_axis_tuser  = w.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(w);
  endtask

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
  endtask

  // drop valid, wait for every expected word, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input blp_reg_e idx, input logic [15:0] value);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {junk, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    // read back
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== value) begin
      $display("%0t: register %0d expected %0d actual %0d", $time, idx, value, prdata[15:0]);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] bp, input logic [15:0] bo,
                           input logic [15:0] lp, input logic [15:0] lo);
    write_reg(REG_BEEP_PERIOD, bp);
    write_reg(REG_BEEP_ON, bo);
    write_reg(REG_LED_PERIOD, lp);
    write_reg(REG_LED_ON, lo);
  endtask

  task automatic run_words(input int n, input bit hold, input bit pause);
    for (int i = 0; i < n; i++) begin
      if (hold && i == 5) hold_req = 1'b1;
      if (pause && i == n / 2) wait_drained();
      send_word(make_word());
      idle_input(pick_gap());
    end
  endtask

  initial begin
    logic [15:0] bp;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: ring count extremes, LED enable and blink corners
    send_word(word_of(CMD_LOAD, 8'h00, 3'b000, 3'b000));
    send_word(word_of(CMD_TICK, 8'hff, 3'b111, 3'b000));
    send_word(word_of(CMD_TICK, 8'h00, 3'b111, 3'b000));
    send_word(word_of(CMD_TICK, 8'h5a, 3'b111, 3'b111));
    send_word(word_of(CMD_TICK, 8'ha5, 3'b000, 3'b111));
    send_word(word_of(CMD_LOAD, 8'hff, 3'b111, 3'b111));
    for (int i = 0; i < 12; i++) begin
      send_word(word_of(CMD_TICK, 8'h00, 3'(i), 3'(i >> 1)));
    end
    send_word(word_of(CMD_LOAD, 8'd2, 3'b000, 3'b000));
    for (int i = 0; i < 5; i++) send_word(word_of(CMD_TICK, 8'h00, 3'b101, 3'b010));
    wait_drained();

    for (int p = 1; p <= 8; p++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      case (p)
        1: load_regs(16'd1, 16'd0, 16'd1, 16'd0);
        2: load_regs(16'd0, 16'd0, 16'd0, 16'd0);
        3: load_regs(16'd3, 16'd2, 16'd4, 16'd2);
        4: load_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        5: load_regs(16'd6, 16'd9, 16'd5, 16'd7);
        6: begin
          bp = 16'($urandom_range(1, 12));
          load_regs(bp, 16'($urandom_range(0, int'(bp) + 2)), 16'($urandom_range(1, 12)),
                    16'($urandom_range(0, 14)));
        end
        7: load_regs(16'd12, 16'd4, 16'd30, 16'd15);
        default: load_regs(BeepPeriodReset, BeepOnReset, LedPeriodReset, LedOnReset);
      endcase
      if (p == 3) tx_calm = 1'b1;
      run_words(66, p == 3, p == 5);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("beep_and_led_tick_pattern verification clean");
    end else begin
      $display("beep_and_led_tick_pattern verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
